// ===== rtl/isl_pkg.sv =====
// Shared types and constants for the indexed sequential list.
// Request/response transfer structs, action and status codes.
// No dependencies.
`timescale 1ns / 1ps

package isl_pkg;

  localparam int unsigned ActW   = 3;
  localparam int unsigned PosW   = 8;
  localparam int unsigned EntryW = 32;
  localparam int unsigned CountW = 9;

  localparam int unsigned DefDepth      = 256;
  localparam int unsigned DefEntryWidth = 32;

  localparam logic [ActW-1:0] ActInsFront = 3'd0;
  localparam logic [ActW-1:0] ActInsBack  = 3'd1;
  localparam logic [ActW-1:0] ActInsAt    = 3'd2;
  localparam logic [ActW-1:0] ActRemFront = 3'd3;
  localparam logic [ActW-1:0] ActRemBack  = 3'd4;
  localparam logic [ActW-1:0] ActRemAt    = 3'd5;
  localparam logic [ActW-1:0] ActReadAt   = 3'd6;

  typedef enum logic [1:0] {
    StatOk    = 2'd0,
    StatFull  = 2'd1,
    StatEmpty = 2'd2,
    StatRange = 2'd3
  } status_e;

  typedef struct packed {
    logic [ActW-1:0]   action;
    logic [PosW-1:0]   position;
    logic [EntryW-1:0] entry_in;
  } req_t;

  typedef struct packed {
    logic [EntryW-1:0] entry_out;
    status_e           status;
    logic [CountW-1:0] entry_count;
  } rsp_t;

endpackage

// ===== rtl/isl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Uses isl_pkg for nothing; parameters set width and depth.
`timescale 1ns / 1ps

module isl_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/indexed_sequential_list.sv =====
// Indexed sequential list: packed ordered list of entries kept in one RAM.
// Depends on isl_pkg and isl_ram.
//
//   port group   direction  handshake               payload
//   in_*         in         in_valid_i / in_stall_o  isl_pkg::req_t
//   out_*        out        out_valid_o / out_stall_i isl_pkg::rsp_t
//
// One request is in flight at a time. A rejected request or an unused action goes
// from Idle through Done to the output register; a read reads its slot in ShiftDown.
// Insert at p shifts the count - p entries from p up in ShiftUp (none for insert at
// the count); remove at p reads the count - p slots from p in ShiftDown and closes
// the gap. The RAM moves one entry per cycle (read one slot, write its neighbour
// next cycle). Reset clears the count and the control state; RAM contents are not
// cleared, slots above the count are never read. A stalled output holds the finished
// response; the next request can transfer after it has moved to the output register.
`timescale 1ns / 1ps

module indexed_sequential_list #(
  parameter int unsigned DEPTH       = isl_pkg::DefDepth,
  parameter int unsigned ENTRY_WIDTH = isl_pkg::DefEntryWidth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  isl_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output isl_pkg::rsp_t out_data_o
);

  import isl_pkg::*;

  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned CmpW  = (CntW > PosW) ? CntW : PosW;
  localparam int unsigned InW   = (ENTRY_WIDTH < EntryW) ? ENTRY_WIDTH : EntryW;

  typedef enum logic [1:0] {
    Idle,
    ShiftUp,
    ShiftDown,
    Done
  } state_e;

  state_e                 state_q;
  logic [CntW-1:0]        count_q;
  logic [AddrW-1:0]       ptr_q;
  logic [AddrW-1:0]       rd_addr_q;
  logic [AddrW-1:0]       lo_q;
  logic [CntW-1:0]        rem_q;
  logic                   pend_q;
  logic                   head_q;
  logic                   pend_head_q;
  logic [ENTRY_WIDTH-1:0] word_q;
  logic [ENTRY_WIDTH-1:0] res_entry_q;
  status_e                res_status_q;
  logic [CntW-1:0]        res_count_q;
  logic                   out_valid_q;
  rsp_t                   out_data_q;

  // request decode
  logic [CmpW-1:0] cnt_x;
  logic [CmpW-1:0] at_x;
  logic            is_ins;
  logic            is_rem;
  status_e         req_status;

  always_comb begin
    cnt_x  = CmpW'(count_q);
    at_x   = '0;
    is_ins = 1'b0;
    is_rem = 1'b0;
    case (in_data_i.action)
      ActInsFront: begin
        is_ins = 1'b1;
      end
      ActInsBack: begin
        is_ins = 1'b1;
        at_x   = cnt_x;
      end
      ActInsAt: begin
        is_ins = 1'b1;
        at_x   = CmpW'(in_data_i.position);
      end
      ActRemFront: begin
        is_rem = 1'b1;
      end
      ActRemBack: begin
        is_rem = 1'b1;
        at_x   = cnt_x - CmpW'(1);
      end
      ActRemAt, ActReadAt: begin
        is_rem = 1'b1;
        at_x   = CmpW'(in_data_i.position);
      end
      default: ;
    endcase

    req_status = StatOk;
    if (is_ins) begin
      if (count_q == CntW'(DEPTH)) begin
        req_status = StatFull;
      end else if (at_x > cnt_x) begin
        req_status = StatRange;
      end
    end else if (is_rem) begin
      if (count_q == '0) begin
        req_status = StatEmpty;
      end else if (at_x >= cnt_x) begin
        req_status = StatRange;
      end
    end
  end

  // RAM port control
  logic                   issue;
  logic                   ram_we;
  logic [AddrW-1:0]       ram_waddr;
  logic [ENTRY_WIDTH-1:0] ram_wdata;
  logic [ENTRY_WIDTH-1:0] ram_rdata;

  assign issue = ((state_q == ShiftUp) || (state_q == ShiftDown)) && (rem_q != '0);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_addr_q;
    ram_wdata = ram_rdata;
    case (state_q)
      ShiftUp: begin
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = rd_addr_q + AddrW'(1);
        end else if (rem_q == '0) begin
          // gap is open: drop the new entry in
          ram_we    = 1'b1;
          ram_waddr = lo_q;
          ram_wdata = word_q;
        end
      end
      ShiftDown: begin
        // first read returns the removed or read entry, later ones close the gap
        if (pend_q && !pend_head_q) begin
          ram_we    = 1'b1;
          ram_waddr = rd_addr_q - AddrW'(1);
        end
      end
      default: ;
    endcase
  end

  isl_ram #(
    .Width(ENTRY_WIDTH),
    .Depth(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (issue),
    .raddr_i(ptr_q),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= Idle;
      count_q      <= '0;
      ptr_q        <= '0;
      rd_addr_q    <= '0;
      lo_q         <= '0;
      rem_q        <= '0;
      pend_q       <= 1'b0;
      head_q       <= 1'b0;
      pend_head_q  <= 1'b0;
      word_q       <= '0;
      res_entry_q  <= '0;
      res_status_q <= StatOk;
      res_count_q  <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != Done)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        Idle: begin
          if (in_valid_i) begin
            word_q       <= ENTRY_WIDTH'(in_data_i.entry_in[InW-1:0]);
            lo_q         <= AddrW'(at_x);
            res_entry_q  <= '0;
            res_status_q <= req_status;
            pend_q       <= 1'b0;
            pend_head_q  <= 1'b0;
            head_q       <= 1'b1;
            if ((req_status != StatOk) || !(is_ins || is_rem)) begin
              res_count_q <= count_q;
              state_q     <= Done;
            end else if (is_ins) begin
              ptr_q       <= AddrW'(count_q - CntW'(1));
              rem_q       <= count_q - CntW'(at_x);
              count_q     <= count_q + CntW'(1);
              res_count_q <= count_q + CntW'(1);
              state_q     <= ShiftUp;
            end else begin
              ptr_q <= AddrW'(at_x);
              if (in_data_i.action == ActReadAt) begin
                rem_q       <= CntW'(1);
                res_count_q <= count_q;
              end else begin
                rem_q       <= count_q - CntW'(at_x);
                count_q     <= count_q - CntW'(1);
                res_count_q <= count_q - CntW'(1);
              end
              state_q <= ShiftDown;
            end
          end
        end
        ShiftUp: begin
          if (issue) begin
            ptr_q     <= ptr_q - AddrW'(1);
            rem_q     <= rem_q - CntW'(1);
            rd_addr_q <= ptr_q;
          end
          pend_q <= issue;
          if (!pend_q && (rem_q == '0)) begin
            state_q <= Done;
          end
        end
        ShiftDown: begin
          if (issue) begin
            ptr_q     <= ptr_q + AddrW'(1);
            rem_q     <= rem_q - CntW'(1);
            rd_addr_q <= ptr_q;
            head_q    <= 1'b0;
          end
          pend_q      <= issue;
          pend_head_q <= head_q && issue;
          if (pend_q && pend_head_q) begin
            res_entry_q <= ram_rdata;
          end
          if (!pend_q && (rem_q == '0)) begin
            state_q <= Done;
          end
        end
        Done: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q            <= 1'b1;
            out_data_q.entry_out   <= EntryW'(res_entry_q[InW-1:0]);
            out_data_q.status      <= res_status_q;
            out_data_q.entry_count <= CountW'(res_count_q);
            state_q                <= Idle;
          end
        end
        default: state_q <= Idle;
      endcase
    end
  end

  assign in_stall_o  = (state_q != Idle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // a taken request always leaves idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q != Idle)
    else $error("request transfer did not start work");

  // the count stays within the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count beyond depth");

  // shifting never reads and writes the same slot in one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && issue |-> ram_waddr != ptr_q)
    else $error("read and write collide on one slot");

  // a response appears only from the completion state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == Done))
    else $error("response raised outside completion");

endmodule
